// File: hw/rtl/primitive_assembly_vertex_dedup_assert.svh
// ---------------------------------------------------------------------------
// primitive assembly assertion macros
// shared concurrent assertion helpers for the rtl
// ---------------------------------------------------------------------------
`ifndef PRIMITIVE_ASSEMBLY_VERTEX_DEDUP_ASSERT_SVH
`define PRIMITIVE_ASSEMBLY_VERTEX_DEDUP_ASSERT_SVH

// clocked assertion, disabled in reset
`define PAVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication to the next cycle
`define PAVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pavd_pkg.sv
// ---------------------------------------------------------------------------
// pavd package
// shared types and constants of the primitive assembly block
// ---------------------------------------------------------------------------
package pavd_pkg;

  localparam int unsigned MAX_POINTS = 256;
  localparam int unsigned PIDX_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned COORD_W    = 21;

  localparam logic [1:0] KIND_STRIP = 2'd0;
  localparam logic [1:0] KIND_FAN   = 2'd1;
  localparam logic [1:0] KIND_LIST  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic clear;
    logic tri_ok;
    vtx_t v0;
    vtx_t v1;
    vtx_t v2;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                corner;
    logic [7:0]                point_index;
    logic                      is_new;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      table_full;
    logic                      last_corner;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/pavd_front.sv
// ---------------------------------------------------------------------------
// pavd front
// vertex history, strip parity and triangle classification
// ---------------------------------------------------------------------------
module pavd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [1:0]                      kind_i,
  input  logic                            mesh_start_i,
  input  logic                            glyph_start_i,
  input  logic signed [pavd_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [pavd_pkg::COORD_W-1:0] vertex_y_i,
  output logic                            cmd_push_o,
  output pavd_pkg::cmd_t                  cmd_o
);

  pavd_pkg::vtx_t anchor_q, anchor_d, prior_q, prior_d, older_q, older_d;
  pavd_pkg::vtx_t cur, a, b;
  logic [1:0]     phase_q, phase_d, phase_eff;
  logic           parity_q, parity_d, par;
  logic           tri_ok, degen;

  always_comb begin
    cur.x     = vertex_x_i;
    cur.y     = vertex_y_i;
    anchor_d  = anchor_q;
    prior_d   = prior_q;
    older_d   = older_q;
    phase_d   = phase_q;
    parity_d  = parity_q;
    phase_eff = mesh_start_i ? 2'd0 : phase_q;
    par       = mesh_start_i ? 1'b0 : ~parity_q;
    tri_ok    = 1'b0;
    a         = older_q;
    b         = prior_q;
    if (kind_i == pavd_pkg::KIND_NONE) begin
      if (mesh_start_i) begin
        phase_d  = 2'd0;
        parity_d = 1'b0;
      end
    end else begin
      parity_d = par;
      unique case (phase_eff)
        2'd0: begin
          anchor_d = cur;
          older_d  = cur;
          phase_d  = 2'd1;
        end
        2'd1: begin
          prior_d = cur;
          phase_d = 2'd2;
        end
        default: begin
          tri_ok  = 1'b1;
          phase_d = 2'd2;
          unique case (kind_i)
            pavd_pkg::KIND_STRIP: begin
              a       = par ? prior_q : older_q;
              b       = par ? older_q : prior_q;
              older_d = prior_q;
              prior_d = cur;
            end
            pavd_pkg::KIND_FAN: begin
              a       = anchor_q;
              older_d = prior_q;
              prior_d = cur;
            end
            default: begin
              phase_d = 2'd0;
            end
          endcase
        end
      endcase
    end
    degen = ((a.x == b.x) && (a.x == cur.x)) || ((a.y == b.y) && (a.y == cur.y));
  end

  assign cmd_o.clear  = glyph_start_i;
  assign cmd_o.tri_ok = tri_ok & ~degen;
  assign cmd_o.v0     = a;
  assign cmd_o.v1     = b;
  assign cmd_o.v2     = cur;
  assign cmd_push_o   = accept_i & (glyph_start_i | (tri_ok & ~degen));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q <= '0;
      prior_q  <= '0;
      older_q  <= '0;
      phase_q  <= 2'd0;
      parity_q <= 1'b0;
    end else if (accept_i) begin
      anchor_q <= anchor_d;
      prior_q  <= prior_d;
      older_q  <= older_d;
      phase_q  <= phase_d;
      parity_q <= parity_d;
    end
  end

endmodule

// File: hw/rtl/pavd_cmd_queue.sv
// ---------------------------------------------------------------------------
// pavd command queue
// two-entry queue of triangle and clear commands
// ---------------------------------------------------------------------------
module pavd_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pavd_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output pavd_pkg::cmd_t    cmd_o,
  output pavd_pkg::q_stat_t stat_o
);

  pavd_pkg::cmd_t ent_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign cmd_o        = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: hw/rtl/pavd_back.sv
// ---------------------------------------------------------------------------
// pavd back
// point table search and append, result queue
// ---------------------------------------------------------------------------
`include "primitive_assembly_vertex_dedup_assert.svh"

module pavd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pavd_pkg::cmd_t    cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  input  logic              res_pop_i,
  output pavd_pkg::res_t    res_o,
  output logic              res_empty_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_READ = 4'b0010,
    B_CMP  = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_e;

  bstate_e                       state_q, state_d;
  pavd_pkg::cmd_t                cmd_q, cmd_d;
  logic [1:0]                    corner_q, corner_d;
  logic [pavd_pkg::CNT_W-1:0]    sidx_q, sidx_d, count_q, count_d;
  logic                          found_q, found_d;
  pavd_pkg::vtx_t                mem [pavd_pkg::MAX_POINTS];
  pavd_pkg::vtx_t                rd_data_q, pt;
  logic                          rd_en, wr_en, has_room;
  pavd_pkg::res_t                res;
  logic                          push;

  pavd_pkg::res_t                oq_q [2];
  logic                          oq_wr_q, oq_rd_q;
  logic [1:0]                    oq_cnt_q;
  logic                          oq_full, do_pop;

  assign oq_full     = (oq_cnt_q == 2'd2);
  assign res_empty_o = (oq_cnt_q == 2'd0);
  assign do_pop      = res_pop_i & ~res_empty_o;
  assign res_o       = oq_q[oq_rd_q];
  assign has_room    = (count_q < pavd_pkg::CNT_W'(pavd_pkg::MAX_POINTS));

  always_comb begin
    unique case (corner_q)
      pavd_pkg::CORNER_0: pt = cmd_q.v0;
      pavd_pkg::CORNER_1: pt = cmd_q.v1;
      default:            pt = cmd_q.v2;
    endcase
  end

  always_comb begin
    res.corner      = corner_q;
    res.point_index = found_q ? 8'(sidx_q) : (has_room ? 8'(count_q) : 8'd0);
    res.is_new      = ~found_q & has_room;
    res.point_x     = pt.x;
    res.point_y     = pt.y;
    res.table_full  = ~found_q & ~has_room;
    res.last_corner = (corner_q == pavd_pkg::CORNER_2);
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    corner_d  = corner_q;
    sidx_d    = sidx_q;
    count_d   = count_q;
    found_d   = found_q;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    push      = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.clear) count_d = '0;
          if (cmd_i.tri_ok) begin
            cmd_d    = cmd_i;
            corner_d = pavd_pkg::CORNER_0;
            sidx_d   = '0;
            state_d  = B_READ;
          end
        end
      end
      B_READ: begin
        if (sidx_q == count_q) begin
          found_d = 1'b0;
          state_d = B_EMIT;
        end else begin
          rd_en   = 1'b1;
          state_d = B_CMP;
        end
      end
      B_CMP: begin
        if (rd_data_q == pt) begin
          found_d = 1'b1;
          state_d = B_EMIT;
        end else begin
          sidx_d  = sidx_q + 1'b1;
          state_d = B_READ;
        end
      end
      B_EMIT: begin
        if (!oq_full) begin
          push = 1'b1;
          if (res.is_new) begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
          end
          sidx_d = '0;
          if (corner_q == pavd_pkg::CORNER_2) begin
            state_d = B_IDLE;
          end else begin
            corner_d = corner_q + 2'd1;
            state_d  = B_READ;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[pavd_pkg::PIDX_W-1:0]] <= pt;
    end
    if (rd_en) begin
      rd_data_q <= mem[sidx_q[pavd_pkg::PIDX_W-1:0]];
    end
    if (push) begin
      oq_q[oq_wr_q] <= res;
    end
    cmd_q <= cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      corner_q <= pavd_pkg::CORNER_0;
      sidx_q   <= '0;
      count_q  <= '0;
      found_q  <= 1'b0;
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
      sidx_q   <= sidx_d;
      count_q  <= count_d;
      found_q  <= found_d;
      if (push)   oq_wr_q <= ~oq_wr_q;
      if (do_pop) oq_rd_q <= ~oq_rd_q;
      oq_cnt_q <= oq_cnt_q + {1'b0, push} - {1'b0, do_pop};
    end
  end

  `PAVD_ASSERT(a_count_bound, count_q <= pavd_pkg::CNT_W'(pavd_pkg::MAX_POINTS), "count overflow")
  `PAVD_ASSERT(a_search_bound, sidx_q <= count_q, "search index beyond table fill")
  `PAVD_ASSERT_NEXT(a_append, push && res.is_new, count_q == $past(count_q) + 1'b1, "append lost")
  `PAVD_ASSERT(a_oq_bound, oq_cnt_q <= 2'd2, "result queue overflow")

endmodule

// File: hw/rtl/primitive_assembly_vertex_dedup.sv
// ---------------------------------------------------------------------------
// primitive assembly with vertex dedup
// strip, fan and list triangles with per-glyph point table lookup
// ---------------------------------------------------------------------------
// channel   dir  handshake          payload
// vertex    in   push / full        kind, mesh_start, glyph_start, vertex_x, vertex_y
// corner    out  pop / empty        corner, point_index, is_new, point_x, point_y,
//                                   table_full, last_corner
//
// a vertex is taken while the two-entry command queue has room
// each corner scans the table entry by entry, read then compare (single read port)
// a triangle is dispatched from the idle state and then takes three corners
// glyph_start empties the table by zeroing its count: no clearing pass after reset
// a full result queue stalls the back end only; the front keeps filling its queue
module primitive_assembly_vertex_dedup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          kind_i,
  input  logic                                mesh_start_i,
  input  logic                                glyph_start_i,
  input  logic signed [pavd_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [pavd_pkg::COORD_W-1:0] vertex_y_i,
  input  logic                                pop,
  output logic                                empty,
  output logic [1:0]                          corner_o,
  output logic [7:0]                          point_index_o,
  output logic                                is_new_o,
  output logic signed [pavd_pkg::COORD_W-1:0] point_x_o,
  output logic signed [pavd_pkg::COORD_W-1:0] point_y_o,
  output logic                                table_full_o,
  output logic                                last_corner_o
);

  pavd_pkg::cmd_t    f_cmd, q_cmd;
  pavd_pkg::q_stat_t q_stat;
  pavd_pkg::res_t    res;
  logic              f_push, b_pop;

  assign full = q_stat.full;

  pavd_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (push & ~q_stat.full),
    .kind_i,
    .mesh_start_i,
    .glyph_start_i,
    .vertex_x_i,
    .vertex_y_i,
    .cmd_push_o    (f_push),
    .cmd_o         (f_cmd)
  );

  pavd_cmd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (f_push),
    .cmd_i  (f_cmd),
    .pop_i  (b_pop),
    .cmd_o  (q_cmd),
    .stat_o (q_stat)
  );

  pavd_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_i       (q_cmd),
    .cmd_empty_i (q_stat.empty),
    .cmd_pop_o   (b_pop),
    .res_pop_i   (pop),
    .res_o       (res),
    .res_empty_o (empty)
  );

  assign corner_o      = res.corner;
  assign point_index_o = res.point_index;
  assign is_new_o      = res.is_new;
  assign point_x_o     = res.point_x;
  assign point_y_o     = res.point_y;
  assign table_full_o  = res.table_full;
  assign last_corner_o = res.last_corner;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// primitive assembly testbench
// drives strip, fan and list vertices through the push/full queue and checks
// every corner popped from the result queue against an in-bench predictor
// of triangle assembly and per-glyph point table dedup
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct {
    logic [1:0]                   kind;
    logic                         mesh_start;
    logic                         glyph_start;
    logic [pavd_pkg::COORD_W-1:0] x;
    logic [pavd_pkg::COORD_W-1:0] y;
    bit                           drain_first;
  } vertex_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] kind_i = '0;
  logic mesh_start_i = 1'b0;
  logic glyph_start_i = 1'b0;
  logic signed [pavd_pkg::COORD_W-1:0] vertex_x_i = '0;
  logic signed [pavd_pkg::COORD_W-1:0] vertex_y_i = '0;
  logic pop = 1'b0;
  logic empty;
  logic [1:0] corner_o;
  logic [7:0] point_index_o;
  logic is_new_o;
  logic signed [pavd_pkg::COORD_W-1:0] point_x_o;
  logic signed [pavd_pkg::COORD_W-1:0] point_y_o;
  logic table_full_o;
  logic last_corner_o;

  always #5 clk_i = ~clk_i;

  primitive_assembly_vertex_dedup dut (.*);

  vertex_item_t   pending_vertices[$];
  pavd_pkg::res_t corners_due[$];
  vertex_item_t   in_flight;
  int             send_gap = 0;
  int             pop_stall = 0;
  int             idle_cycles = 0;
  bit             failed = 1'b0;
  bit             calm_send = 1'b0;
  bit             calm_pop = 1'b0;

  // predictor state
  logic [2*pavd_pkg::COORD_W-1:0] glyph_points[pavd_pkg::MAX_POINTS];
  logic [pavd_pkg::CNT_W-1:0]     glyph_count = '0;
  logic [2*pavd_pkg::COORD_W-1:0] fan_pivot = '0;
  logic [2*pavd_pkg::COORD_W-1:0] last_vtx = '0;
  logic [2*pavd_pkg::COORD_W-1:0] second_vtx = '0;
  logic [1:0]                     mesh_phase = '0;
  logic                           odd_pos = 1'b0;

  task automatic place_corner(input logic [1:0] which,
                              input logic [2*pavd_pkg::COORD_W-1:0] pt);
    pavd_pkg::res_t r;
    int             hit;
    hit = -1;
    for (int i = 0; i < glyph_count; i++) begin
      if (hit < 0 && glyph_points[i] == pt) hit = i;
    end
    r.corner      = which;
    r.point_x     = pt[2*pavd_pkg::COORD_W-1:pavd_pkg::COORD_W];
    r.point_y     = pt[pavd_pkg::COORD_W-1:0];
    r.is_new      = 1'b0;
    r.table_full  = 1'b0;
    r.point_index = '0;
    r.last_corner = (which == pavd_pkg::CORNER_2);
    if (hit >= 0) begin
      r.point_index = hit[7:0];
    end else if (glyph_count < pavd_pkg::MAX_POINTS) begin
      glyph_points[glyph_count] = pt;
      r.point_index = glyph_count[7:0];
      r.is_new      = 1'b1;
      glyph_count++;
    end else begin
      r.table_full = 1'b1;
    end
    corners_due.insert(corners_due.size(), r);
  endtask

  task automatic emit_triangle(input logic [2*pavd_pkg::COORD_W-1:0] a, b, c);
    if ((a[2*pavd_pkg::COORD_W-1:pavd_pkg::COORD_W] ==
         b[2*pavd_pkg::COORD_W-1:pavd_pkg::COORD_W] &&
         a[2*pavd_pkg::COORD_W-1:pavd_pkg::COORD_W] ==
         c[2*pavd_pkg::COORD_W-1:pavd_pkg::COORD_W]) ||
        (a[pavd_pkg::COORD_W-1:0] == b[pavd_pkg::COORD_W-1:0] &&
         a[pavd_pkg::COORD_W-1:0] == c[pavd_pkg::COORD_W-1:0]))
      return;
    place_corner(pavd_pkg::CORNER_0, a);
    place_corner(pavd_pkg::CORNER_1, b);
    place_corner(pavd_pkg::CORNER_2, c);
  endtask

  task automatic assemble_vertex(input vertex_item_t v);
    logic [2*pavd_pkg::COORD_W-1:0] cur;
    logic                           par;
    cur = {v.x, v.y};
    if (v.glyph_start) glyph_count = '0;
    if (v.mesh_start) begin
      mesh_phase = 2'd0;
      odd_pos    = 1'b1;
    end
    if (v.kind == pavd_pkg::KIND_NONE) begin
      if (v.mesh_start) odd_pos = 1'b0;
      return;
    end
    par = v.mesh_start ? 1'b0 : ~odd_pos;
    odd_pos = par;
    if (mesh_phase == 2'd0) begin
      fan_pivot  = cur;
      second_vtx = cur;
      mesh_phase = 2'd1;
    end else if (mesh_phase == 2'd1) begin
      last_vtx   = cur;
      mesh_phase = 2'd2;
    end else if (v.kind == pavd_pkg::KIND_STRIP) begin
      if (par) emit_triangle(last_vtx, second_vtx, cur);
      else emit_triangle(second_vtx, last_vtx, cur);
      second_vtx = last_vtx;
      last_vtx   = cur;
    end else if (v.kind == pavd_pkg::KIND_FAN) begin
      emit_triangle(fan_pivot, last_vtx, cur);
      second_vtx = last_vtx;
      last_vtx   = cur;
    end else begin
      emit_triangle(second_vtx, last_vtx, cur);
      mesh_phase = 2'd0;
    end
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic nxt_push;
    if (rst_ni) begin
      nxt_push = push;
      if (push && !full) begin
        assemble_vertex(in_flight);
        nxt_push = 1'b0;
        if ($urandom_range(0, 49) == 0) calm_send = ~calm_send;
        send_gap = pick_gap(calm_send);
      end
      if (!nxt_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_vertices.size() > 0 &&
                     !(pending_vertices[0].drain_first && corners_due.size() > 0)) begin
          in_flight = pending_vertices.pop_front();
          kind_i        <= in_flight.kind;
          mesh_start_i  <= in_flight.mesh_start;
          glyph_start_i <= in_flight.glyph_start;
          vertex_x_i    <= in_flight.x;
          vertex_y_i    <= in_flight.y;
          nxt_push = 1'b1;
        end
      end
      push <= nxt_push;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pavd_pkg::res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (corners_due.size() == 0) begin
          $error("unexpected item: corner %0d x %0d", corner_o, point_x_o);
          failed = 1'b1;
        end else begin
          want = corners_due.pop_front();
          if (corner_o !== want.corner) begin
            $error("corner: expected %0d, got %0d", want.corner, corner_o);
            failed = 1'b1;
          end
          if (point_index_o !== want.point_index) begin
            $error("point_index: expected %0d, got %0d", want.point_index, point_index_o);
            failed = 1'b1;
          end
          if (is_new_o !== want.is_new) begin
            $error("is_new: expected %0d, got %0d", want.is_new, is_new_o);
            failed = 1'b1;
          end
          if (point_x_o !== want.point_x) begin
            $error("point_x: expected %0d, got %0d", want.point_x, point_x_o);
            failed = 1'b1;
          end
          if (point_y_o !== want.point_y) begin
            $error("point_y: expected %0d, got %0d", want.point_y, point_y_o);
            failed = 1'b1;
          end
          if (table_full_o !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, table_full_o);
            failed = 1'b1;
          end
          if (last_corner_o !== want.last_corner) begin
            $error("last_corner: expected %0d, got %0d", want.last_corner, last_corner_o);
            failed = 1'b1;
          end
        end
      end
      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else begin
        if ($urandom_range(0, 59) == 0) calm_pop = ~calm_pop;
        pop_stall = pick_gap(calm_pop);
        pop <= (pop_stall == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("primitive_assembly_vertex_dedup: mismatch");
      $finish;
    end
  end

  task automatic add_vertex(input logic [1:0] k, input int ms, gs,
                            input int x, y, input bit hold = 1'b0);
    vertex_item_t v;
    v.kind = k; v.mesh_start = (ms != 0); v.glyph_start = (gs != 0);
    v.x = pavd_pkg::COORD_W'(x); v.y = pavd_pkg::COORD_W'(y); v.drain_first = hold;
    pending_vertices.insert(pending_vertices.size(), v);
  endtask

  function automatic logic [pavd_pkg::COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return pavd_pkg::COORD_W'($signed($urandom_range(0, 7)) - 3);
    if (r < 7) return {1'b1, {(pavd_pkg::COORD_W-1){1'b0}}};
    if (r < 8) return {1'b0, {(pavd_pkg::COORD_W-1){1'b1}}};
    return pavd_pkg::COORD_W'($urandom());
  endfunction

  initial begin
    logic [pavd_pkg::COORD_W-1:0] lo, hi;
    int len, meshes;
    logic [1:0] k;
    lo = {1'b1, {(pavd_pkg::COORD_W-1){1'b0}}};
    hi = {1'b0, {(pavd_pkg::COORD_W-1){1'b1}}};

    // directed: strip with both parities, extremes
    add_vertex(pavd_pkg::KIND_STRIP, 1, 1, lo, lo);
    add_vertex(pavd_pkg::KIND_STRIP, 0, 0, hi, lo);
    add_vertex(pavd_pkg::KIND_STRIP, 0, 0, lo, hi);
    add_vertex(pavd_pkg::KIND_STRIP, 0, 0, hi, hi);
    add_vertex(pavd_pkg::KIND_STRIP, 0, 0, 0, 0);
    // fan, repeated points found again
    add_vertex(pavd_pkg::KIND_FAN, 1, 0, 0, 0);
    add_vertex(pavd_pkg::KIND_FAN, 0, 0, hi, hi);
    add_vertex(pavd_pkg::KIND_FAN, 0, 0, lo, hi);
    add_vertex(pavd_pkg::KIND_FAN, 0, 0, 5, 5);
    // list, degenerate then good, then incomplete tail, held until drained
    add_vertex(pavd_pkg::KIND_LIST, 1, 1, 7, 1, 1'b1);
    add_vertex(pavd_pkg::KIND_LIST, 0, 0, 7, 2);
    add_vertex(pavd_pkg::KIND_LIST, 0, 0, 7, 3);
    add_vertex(pavd_pkg::KIND_LIST, 0, 0, 1, 9);
    add_vertex(pavd_pkg::KIND_LIST, 0, 0, 2, 4);
    add_vertex(pavd_pkg::KIND_LIST, 0, 0, 1, 4);
    add_vertex(pavd_pkg::KIND_LIST, 0, 0, 1, 1);
    add_vertex(pavd_pkg::KIND_LIST, 0, 0, 3, 3);
    // unused kind, then kind changes inside one sub-mesh
    add_vertex(pavd_pkg::KIND_NONE, 1, 0, 9, 9);
    add_vertex(pavd_pkg::KIND_STRIP, 1, 0, 1, 2);
    add_vertex(pavd_pkg::KIND_NONE, 0, 1, 4, 4);
    add_vertex(pavd_pkg::KIND_FAN, 0, 0, 3, 5);
    add_vertex(pavd_pkg::KIND_LIST, 0, 0, 6, 1);
    add_vertex(pavd_pkg::KIND_STRIP, 0, 0, 8, 8);

    // random sub-meshes, small tables
    meshes = 0;
    while (pending_vertices.size() < 210) begin
      k = ($urandom_range(0, 19) == 0) ? pavd_pkg::KIND_NONE : 2'($urandom_range(0, 2));
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        add_vertex(($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : k,
                   i == 0 || $urandom_range(0, 29) == 0,
                   (i == 0 && meshes % 4 == 0) || $urandom_range(0, 49) == 0,
                   pick_coord(), pick_coord(), meshes == 20 && i == 0);
      meshes++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_vertices.size() == 0 && !push);
    wait (corners_due.size() == 0);
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("primitive_assembly_vertex_dedup: match");
    end else begin
      $display("primitive_assembly_vertex_dedup: mismatch");
    end
    $finish;
  end

endmodule
